FILE: hdl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the CRC-32 frame deframer
// Holds the frame markers, the CRC polynomial, register reset values, the
// command and response records passed between the front and back ends, and
// the byte-wise CRC update function.
// ----------------------------------------------------------------------------
package cfd_pkg;

   // Frame markers and CRC polynomial (reflected form).
   localparam logic [7:0]  START_MARK = 8'hA5;
   localparam logic [7:0]  END_MARK   = 8'h5A;
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

   // Configuration register indexes and reset values.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_VALUE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_PAYLOAD = 1'd1;
   localparam logic [31:0] SEED_RESET        = 32'h35769521;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd2048;

   // Result kinds as they appear on the response channel.
   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_GOOD    = 3'd1,
      KIND_CRC_ERR = 3'd2,
      KIND_BAD_END = 3'd3,
      KIND_LEN_ERR = 3'd4
   } kind_type;

   // Operations the back end carries out on its CRC state.
   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_CRC   = 2'd1,
      OP_RCV   = 2'd2,
      OP_CHECK = 2'd3
   } op_type;

   // One classified byte, queued from the front end to the back end.
   typedef struct packed {
      op_type      op;
      logic        emit;
      kind_type    kind;
      logic [7:0]  data;
      logic [23:0] hdr;
      logic [15:0] count;
   } cmd_type;

   // One result transaction as it waits in the response queue.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  frame_type;
      logic [7:0]  frame_cmd;
      logic [7:0]  frame_ack;
      logic [15:0] payload_count;
      logic        frame_end;
   } rsp_type;

   // Reflected CRC-32 update with one byte, one bit per step.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [7:0]  b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

FILE: hdl/cfd_fifo.sv
// ----------------------------------------------------------------------------
// cfd_fifo: small first-word-fall-through queue
// Register-based queue used between the front and back ends and in front of
// the response channel. The oldest entry is shown on pop_data while not empty.
// ----------------------------------------------------------------------------
module cfd_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer wrap and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; entries are read only after being written.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   // Occupancy never exceeds the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("cfd_fifo: occupancy above depth");

   // A lone push grows the occupancy by exactly one.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("cfd_fifo: push did not grow occupancy");
`endif

endmodule

FILE: hdl/cfd_front.sv
// ----------------------------------------------------------------------------
// cfd_front: frame parser of the deframer
// Hunts for the start marker, tracks the byte position inside the frame,
// captures lengths and header bytes, and turns each accepted byte into one
// back-end command; version, total-length and hunting-dropped bytes make none.
// ----------------------------------------------------------------------------
module cfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_rx_byte,
   input  logic [15:0]      max_payload,
   input  logic             cmd_full,
   output logic             cmd_push,
   output cfd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CRC,
      PH_END
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [23:0] hdr_ff, hdr_in;

   logic        accept;
   logic [15:0] dlen_full;
   logic [16:0] idx;
   logic [16:0] pos_next;
   logic [15:0] delivered;

   assign accept    = req_push && !cmd_full;
   assign dlen_full = {dlen_ff[15:8], req_rx_byte};
   assign idx       = pos_ff - 17'd9;
   assign pos_next  = pos_ff + 17'd1;
   assign delivered = (dlen_ff < max_payload) ? dlen_ff : max_payload;

   // Frame sequencing and command classification.
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      total_in  = total_ff;
      dlen_in   = dlen_ff;
      hdr_in    = hdr_ff;
      cmd_push  = 1'b0;
      cmd.op    = cfd_pkg::OP_CRC;
      cmd.emit  = 1'b0;
      cmd.kind  = cfd_pkg::KIND_PAYLOAD;
      cmd.data  = req_rx_byte;
      cmd.hdr   = hdr_ff;
      cmd.count = 16'd0;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               pos_in = pos_next;
               priority if (pos_ff == 17'd2) begin
                  total_in = {req_rx_byte, 8'd0};
               end else if (pos_ff == 17'd3) begin
                  total_in = {total_ff[15:8], req_rx_byte};
               end else if (pos_ff >= 17'd4 && pos_ff <= 17'd6) begin
                  hdr_in   = {hdr_ff[15:0], req_rx_byte};
                  cmd_push = 1'b1;
               end else if (pos_ff == 17'd7) begin
                  dlen_in  = {req_rx_byte, 8'd0};
                  cmd_push = 1'b1;
               end else if (pos_ff == 17'd8) begin
                  dlen_in  = dlen_full;
                  cmd_push = 1'b1;
                  if ({1'b0, total_ff} != ({1'b0, dlen_full} + 17'd5)) begin
                     // Total length disagrees with data length: report at once.
                     phase_in  = PH_HUNT;
                     cmd.emit  = 1'b1;
                     cmd.kind  = cfd_pkg::KIND_LEN_ERR;
                  end else begin
                     phase_in = (dlen_full != 16'd0) ? PH_PAYLOAD : PH_CRC;
                  end
               end else begin
                  // The version byte carries nothing.
               end
            end
            PH_PAYLOAD: begin
               pos_in   = pos_next;
               cmd_push = 1'b1;
               if ((idx + 17'd1) >= {1'b0, dlen_ff}) begin
                  phase_in = PH_CRC;
               end
               if (idx < {1'b0, max_payload}) begin
                  cmd.emit  = 1'b1;
                  cmd.count = idx[15:0] + 16'd1;
               end
            end
            PH_CRC: begin
               pos_in   = pos_next;
               cmd_push = 1'b1;
               cmd.op   = cfd_pkg::OP_RCV;
               if (pos_next >= ({1'b0, dlen_ff} + 17'd13)) begin
                  phase_in = PH_END;
               end
            end
            PH_END: begin
               phase_in  = PH_HUNT;
               cmd_push  = 1'b1;
               cmd.op    = cfd_pkg::OP_CHECK;
               cmd.emit  = 1'b1;
               cmd.kind  = (req_rx_byte != cfd_pkg::END_MARK) ?
                           cfd_pkg::KIND_BAD_END : cfd_pkg::KIND_GOOD;
               cmd.count = delivered;
            end
            PH_HUNT: begin
               if (req_rx_byte == cfd_pkg::START_MARK) begin
                  phase_in = PH_HEADER;
                  pos_in   = 17'd1;
                  total_in = 16'd0;
                  dlen_in  = 16'd0;
                  hdr_in   = 24'd0;
                  cmd_push = 1'b1;
                  cmd.op   = cfd_pkg::OP_INIT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         total_ff <= '0;
         dlen_ff  <= '0;
         hdr_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         total_ff <= total_in;
         dlen_ff  <= dlen_in;
         hdr_ff   <= hdr_in;
      end
   end

`ifndef SYNTHESIS
   // A stray byte while hunting never reaches the back end.
   a_hunt_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_HUNT && req_rx_byte != cfd_pkg::START_MARK)
      |-> !cmd_push)
      else $error("cfd_front: stray byte produced a command");
`endif

endmodule

FILE: hdl/cfd_back.sv
// ----------------------------------------------------------------------------
// cfd_back: CRC engine and result builder of the deframer
// Takes front-end commands one per cycle, save while a result waits on a full
// response queue; keeps the running and received CRC values, queues results.
// ----------------------------------------------------------------------------
module cfd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      init_seed,
   input  logic             cmd_empty,
   input  cfd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output cfd_pkg::rsp_type rsp
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcv_ff, rcv_in;
   logic        crc_bad;

   // A command that yields a result waits for room in the response queue.
   assign cmd_pop  = !cmd_empty && (!cmd.emit || !rsp_full);
   assign rsp_push = cmd_pop && cmd.emit;
   assign crc_bad  = (~crc_ff != rcv_ff);

   // Result fields; a good end marker still fails on a CRC mismatch.
   always_comb begin
      rsp.kind          = cmd.kind;
      if (cmd.op == cfd_pkg::OP_CHECK && cmd.kind == cfd_pkg::KIND_GOOD && crc_bad) begin
         rsp.kind = cfd_pkg::KIND_CRC_ERR;
      end
      rsp.data_byte     = (cmd.kind == cfd_pkg::KIND_PAYLOAD) ? cmd.data : 8'd0;
      rsp.frame_type    = cmd.hdr[23:16];
      rsp.frame_cmd     = cmd.hdr[15:8];
      rsp.frame_ack     = cmd.hdr[7:0];
      rsp.payload_count = cmd.count;
      rsp.frame_end     = (cmd.kind != cfd_pkg::KIND_PAYLOAD);
   end

   // CRC state updates.
   always_comb begin
      crc_in = crc_ff;
      rcv_in = rcv_ff;
      if (cmd_pop) begin
         unique case (cmd.op)
            cfd_pkg::OP_INIT: begin
               crc_in = ~init_seed;
               rcv_in = 32'd0;
            end
            cfd_pkg::OP_CRC: begin
               crc_in = cfd_pkg::crc_byte(crc_ff, cmd.data);
            end
            cfd_pkg::OP_RCV: begin
               rcv_in = {rcv_ff[23:0], cmd.data};
            end
            cfd_pkg::OP_CHECK: begin
               // Comparison only; state is left as it is.
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
         rcv_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         rcv_ff <= rcv_in;
      end
   end

`ifndef SYNTHESIS
   // A result is never written into a full response queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("cfd_back: result pushed into full queue");
`endif

endmodule

FILE: hdl/crc32_frame_deframer.sv
// ----------------------------------------------------------------------------
// crc32_frame_deframer: marker-framed packet receiver with CRC-32 check
// Usage: bytes enter on the req_ queue port (req_push, req_full,
// req_rx_byte); a transaction completes when req_push is high and req_full
// low. Results leave on the rsp_ queue port: while rsp_empty is low the oldest
// result is on the rsp_ fields, and rsp_pop takes it. Each payload byte up to
// max_payload gives one result, and each frame ends with one status result.
// Registers are written on the csr_ port (csr_valid, csr_ready, csr_index,
// csr_wdata); the user must write them only while the block is idle, as the
// block does not enforce it. csr_ready is always high. Throughput is one
// byte per cycle while req_full is low, set by the byte-wide CRC update in
// the back end. A byte that yields a result passes through the command queue
// and then the result queue before it shows on the rsp_ port. When the
// receiver stalls, the result queue fills, then the command queue, and
// req_full rises. Synchronous reset returns the parser to hunting for the
// start marker, empties both queues and restores the register reset values.
// ----------------------------------------------------------------------------
module crc32_frame_deframer #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [2:0]                           rsp_kind,
   output logic [7:0]                           rsp_data_byte,
   output logic [7:0]                           rsp_frame_type,
   output logic [7:0]                           rsp_frame_cmd,
   output logic [7:0]                           rsp_frame_ack,
   output logic [15:0]                          rsp_payload_count,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cfd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                          csr_wdata
);

   localparam int CMD_W = $bits(cfd_pkg::cmd_type);
   localparam int RSP_W = $bits(cfd_pkg::rsp_type);

   logic [31:0]      seed_ff, seed_in;
   logic [15:0]      max_ff, max_in;

   cfd_pkg::cmd_type cmd_wr, cmd_rd;
   cfd_pkg::rsp_type rsp_wr, rsp_rd;
   logic [CMD_W-1:0] cmd_rd_bits;
   logic [RSP_W-1:0] rsp_rd_bits;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic             rsp_push, rsp_full;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      seed_in = seed_ff;
      max_in  = max_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cfd_pkg::CSR_SEED_VALUE:  seed_in = csr_wdata;
            cfd_pkg::CSR_MAX_PAYLOAD: max_in  = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= cfd_pkg::SEED_RESET;
         max_ff  <= cfd_pkg::MAX_PAYLOAD_RESET;
      end else begin
         seed_ff <= seed_in;
         max_ff  <= max_in;
      end
   end

   // Front end: parsing and classification.
   cfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .max_payload (max_ff),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd         (cmd_wr)
   );

   assign req_full = cmd_full;

   // Command queue between front and back ends.
   cfd_fifo #(
      .DEPTH (CMD_DEPTH),
      .WIDTH (CMD_W)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_bits),
      .empty     (cmd_empty)
   );

   assign cmd_rd = cfd_pkg::cmd_type'(cmd_rd_bits);

   // Back end: CRC and result building.
   cfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .init_seed (seed_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   // Result queue in front of the response port.
   cfd_fifo #(
      .DEPTH (RSP_DEPTH),
      .WIDTH (RSP_W)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rd_bits),
      .empty     (rsp_empty)
   );

   assign rsp_rd            = cfd_pkg::rsp_type'(rsp_rd_bits);
   assign rsp_kind          = rsp_rd.kind;
   assign rsp_data_byte     = rsp_rd.data_byte;
   assign rsp_frame_type    = rsp_rd.frame_type;
   assign rsp_frame_cmd     = rsp_rd.frame_cmd;
   assign rsp_frame_ack     = rsp_rd.frame_ack;
   assign rsp_payload_count = rsp_rd.payload_count;
   assign rsp_frame_end     = rsp_rd.frame_end;

endmodule

FILE: tb/crc32_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// crc32_frame_deframer_tb: self-checking testbench of the CRC-32 frame deframer
// Feeds a byte stream into the request queue port and checks every response
// transaction against a predictor of the deframer that runs alongside. A short
// table of directed bytes comes first. Random frames follow: mostly
// well-formed, some with a corrupted CRC, end marker or length field, plus
// line noise and cut-off headers. Register settings change between phases,
// often in the middle of a frame. Both ports idle at random.
// ----------------------------------------------------------------------------
module crc32_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS  = 850;
   localparam int unsigned PHASE_ITEMS   = 140;
   localparam int unsigned QUIET_AFTER   = 720;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned PLAN_ROWS     = 27;

   // Parser phases of the predictor.
   typedef enum logic [2:0] {
      FR_HUNT,
      FR_HEADER,
      FR_PAYLOAD,
      FR_CRC,
      FR_TRAILER
   } frame_phase_type;

   // One directed byte, with the response it must cause where that is obvious.
   typedef struct packed {
      logic [7:0]        rx;
      logic              typed;
      cfd_pkg::kind_type kind;
      logic [7:0]        data;
      logic [15:0]       count;
   } plan_row_type;

   // Noise while hunting, a length mismatch with 0xA5 inside the header, and a
   // one-byte frame whose end marker and CRC are both wrong.
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h5A, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hFF, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hA5, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hFF, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hFF, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hA5, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hFF, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hFF, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hFF, 1'b1, cfd_pkg::KIND_LEN_ERR, 8'h00, 16'd0},
      '{8'hA5, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hFF, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h06, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h5A, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hA5, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h01, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hA5, 1'b1, cfd_pkg::KIND_PAYLOAD, 8'hA5, 16'd1},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'h00, 1'b0, cfd_pkg::KIND_PAYLOAD, 8'h00, 16'd0},
      '{8'hFF, 1'b1, cfd_pkg::KIND_BAD_END, 8'h00, 16'd1}
   };

   // Block inputs, all known from time zero.
   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_push    = 1'b0;
   logic [7:0]                          req_rx_byte = 8'h00;
   logic                                rsp_pop     = 1'b0;
   logic                                csr_valid   = 1'b0;
   logic [cfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [31:0]                         csr_wdata   = '0;

   // Block outputs.
   logic        req_full;
   logic        rsp_empty;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_frame_type;
   logic [7:0]  rsp_frame_cmd;
   logic [7:0]  rsp_frame_ack;
   logic [15:0] rsp_payload_count;
   logic        rsp_frame_end;
   logic        csr_ready;

   // Predictor state and its copy of the registers.
   frame_phase_type fr_phase;
   logic [16:0]     byte_pos;
   logic [15:0]     tot_len;
   logic [15:0]     dat_len;
   logic [23:0]     hdr_bytes;
   logic [31:0]     crc_acc;
   logic [31:0]     crc_rx;
   logic [31:0]     cfg_seed;
   logic [15:0]     cfg_max;

   cfd_pkg::rsp_type awaited_results [$];
   logic [7:0]       rx_stream [$];
   cfd_pkg::rsp_type head_rsp;
   int unsigned      n_errors    = 0;
   int unsigned      cycle_count = 0;
   int unsigned      pop_hold    = 0;
   bit               quiet       = 1'b0;

   crc32_frame_deframer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_cmd     (rsp_frame_cmd),
      .rsp_frame_ack     (rsp_frame_ack),
      .rsp_payload_count (rsp_payload_count),
      .rsp_frame_end     (rsp_frame_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   // Reflected CRC-32, one message bit folded in per step.
   function automatic logic [31:0] crc_update(input logic [31:0] acc,
                                              input logic [7:0]  value);
      logic [31:0] c;
      logic        fb;
      c = acc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ value[k];
         c  = c >> 1;
         if (fb) c = c ^ cfd_pkg::CRC_POLY;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      n_errors++;
   endtask

   task automatic reset_predictor();
      fr_phase  = FR_HUNT;
      byte_pos  = '0;
      tot_len   = '0;
      dat_len   = '0;
      hdr_bytes = '0;
      crc_acc   = '0;
      crc_rx    = '0;
      cfg_seed  = cfd_pkg::SEED_RESET;
      cfg_max   = cfd_pkg::MAX_PAYLOAD_RESET;
   endtask

   // Advances the predicted deframer by one byte and returns the response
   // transaction that byte causes, if any.
   task automatic deframe_byte(input logic [7:0] b, output bit got,
                               output cfd_pkg::rsp_type res);
      int unsigned delivered;
      int unsigned idx;
      delivered = 32'((dat_len < cfg_max) ? dat_len : cfg_max);
      got = 1'b0;
      res = '0;
      res.frame_type = hdr_bytes[23:16];
      res.frame_cmd  = hdr_bytes[15:8];
      res.frame_ack  = hdr_bytes[7:0];
      case (fr_phase)
         FR_HEADER: begin
            if (byte_pos == 17'd2) begin
               tot_len = {b, 8'h00};
            end else if (byte_pos == 17'd3) begin
               tot_len[7:0] = b;
            end else if (byte_pos >= 17'd4 && byte_pos <= 17'd6) begin
               hdr_bytes = {hdr_bytes[15:0], b};
               crc_acc   = crc_update(crc_acc, b);
            end else if (byte_pos == 17'd7) begin
               dat_len = {b, 8'h00};
               crc_acc = crc_update(crc_acc, b);
            end else if (byte_pos == 17'd8) begin
               dat_len[7:0] = b;
               crc_acc      = crc_update(crc_acc, b);
            end
            if (byte_pos == 17'd8) begin
               byte_pos = 17'd9;
               // The length fields must agree before any payload is taken.
               if (32'(tot_len) != 32'(dat_len) + 32'd5) begin
                  fr_phase          = FR_HUNT;
                  got               = 1'b1;
                  res.kind          = cfd_pkg::KIND_LEN_ERR;
                  res.frame_type    = hdr_bytes[23:16];
                  res.frame_cmd     = hdr_bytes[15:8];
                  res.frame_ack     = hdr_bytes[7:0];
                  res.payload_count = 16'd0;
                  res.frame_end     = 1'b1;
               end else begin
                  fr_phase = (dat_len != 16'd0) ? FR_PAYLOAD : FR_CRC;
               end
            end else begin
               byte_pos = byte_pos + 17'd1;
            end
         end
         FR_PAYLOAD: begin
            crc_acc  = crc_update(crc_acc, b);
            idx      = 32'(byte_pos) - 32'd9;
            byte_pos = byte_pos + 17'd1;
            if (idx + 32'd1 >= 32'(dat_len)) fr_phase = FR_CRC;
            // Bytes beyond the limit still count toward the CRC only.
            if (idx < 32'(cfg_max)) begin
               got               = 1'b1;
               res.kind          = cfd_pkg::KIND_PAYLOAD;
               res.data_byte     = b;
               res.payload_count = 16'(idx + 32'd1);
               res.frame_end     = 1'b0;
            end
         end
         FR_CRC: begin
            crc_rx   = {crc_rx[23:0], b};
            byte_pos = byte_pos + 17'd1;
            if (32'(byte_pos) >= 32'(dat_len) + 32'd13) fr_phase = FR_TRAILER;
         end
         FR_TRAILER: begin
            fr_phase = FR_HUNT;
            got      = 1'b1;
            // A bad end marker outranks a CRC error.
            if (b != cfd_pkg::END_MARK) res.kind = cfd_pkg::KIND_BAD_END;
            else if (~crc_acc != crc_rx) res.kind = cfd_pkg::KIND_CRC_ERR;
            else res.kind = cfd_pkg::KIND_GOOD;
            res.payload_count = 16'(delivered);
            res.frame_end     = 1'b1;
         end
         default: begin
            fr_phase = FR_HUNT;
            // The seed is taken when the start marker arrives.
            if (b == cfd_pkg::START_MARK) begin
               fr_phase  = FR_HEADER;
               byte_pos  = 17'd1;
               tot_len   = '0;
               dat_len   = '0;
               hdr_bytes = '0;
               crc_rx    = '0;
               crc_acc   = ~cfg_seed;
            end
         end
      endcase
   endtask

   // Pushes one byte, after an optional idle burst, and records what it causes.
   task automatic send_byte(input logic [7:0] value, output bit got,
                            output cfd_pkg::rsp_type res);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_full);
      deframe_byte(value, got, res);
      if (got) awaited_results.push_back(res);
   endtask

   // Stops the input and waits until the block has nothing left in flight.
   task automatic settle();
      req_push <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back; the block must be idle.
   task automatic set_registers(input logic [31:0] seed, input logic [15:0] max_bytes);
      csr_valid <= 1'b1;
      csr_index <= cfd_pkg::CSR_SEED_VALUE;
      csr_wdata <= seed;
      do @(posedge clock); while (!csr_ready);
      cfg_seed = seed;
      csr_index <= cfd_pkg::CSR_MAX_PAYLOAD;
      csr_wdata <= {16'd0, max_bytes};
      do @(posedge clock); while (!csr_ready);
      cfg_max = max_bytes;
      csr_valid <= 1'b0;
   endtask

   // Appends the next piece of the random byte stream: mostly whole frames,
   // some of them flawed, plus noise and headers that break off.
   task automatic queue_frame();
      int unsigned style;
      int unsigned flaw;
      int unsigned pick;
      logic [15:0] dlen;
      logic [15:0] total;
      logic [31:0] acc;
      logic [31:0] fcs;
      logic [7:0]  b;
      logic [7:0]  end_byte;
      logic [7:0]  head [5];
      style = $urandom_range(0, 99);
      if (style < 10) begin
         repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom);
            if (b == cfd_pkg::START_MARK) b = ~b;
            rx_stream.push_back(b);
         end
      end else if (style < 15) begin
         rx_stream.push_back(cfd_pkg::START_MARK);
         repeat ($urandom_range(1, 8)) rx_stream.push_back(8'($urandom));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 90) dlen = 16'($urandom_range(0, 12));
         else if (pick < 98) dlen = 16'($urandom_range(13, 40));
         else dlen = 16'($urandom_range(200, 300));
         // Below 8 length mismatch, below 18 CRC, below 26 end, below 30 both.
         flaw  = $urandom_range(0, 99);
         total = dlen + 16'd5;
         if (flaw < 8) total = total + 16'($urandom_range(1, 65535));
         head[0] = 8'($urandom);
         head[1] = 8'($urandom);
         head[2] = 8'($urandom);
         head[3] = dlen[15:8];
         head[4] = dlen[7:0];
         acc = ~cfg_seed;
         rx_stream.push_back(cfd_pkg::START_MARK);
         rx_stream.push_back(8'($urandom));
         rx_stream.push_back(total[15:8]);
         rx_stream.push_back(total[7:0]);
         for (int i = 0; i < 5; i++) begin
            rx_stream.push_back(head[i]);
            acc = crc_update(acc, head[i]);
         end
         if (flaw >= 8) begin
            repeat (dlen) begin
               b = 8'($urandom);
               rx_stream.push_back(b);
               acc = crc_update(acc, b);
            end
            fcs = ~acc;
            if (flaw < 18 || (flaw >= 26 && flaw < 30)) begin
               fcs = fcs ^ (32'd1 << $urandom_range(0, 31));
            end
            rx_stream.push_back(fcs[31:24]);
            rx_stream.push_back(fcs[23:16]);
            rx_stream.push_back(fcs[15:8]);
            rx_stream.push_back(fcs[7:0]);
            end_byte = cfd_pkg::END_MARK;
            if (flaw >= 18 && flaw < 30) begin
               do end_byte = 8'($urandom); while (end_byte == cfd_pkg::END_MARK);
            end
            rx_stream.push_back(end_byte);
         end
      end
   endtask

   // Response side: pops with random stall bursts, none in the quiet tail.
   always @(posedge clock) begin
      if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         pop_hold <= $urandom_range(0, 10);
         rsp_pop  <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Each popped response transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("response with none expected, kind %0d", rsp_kind));
         end else begin
            head_rsp = awaited_results.pop_front();
            if (rsp_kind != head_rsp.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, head_rsp.kind));
            if (rsp_data_byte != head_rsp.data_byte)
               report_mismatch($sformatf("data_byte %02h, expected %02h",
                                         rsp_data_byte, head_rsp.data_byte));
            if (rsp_frame_type != head_rsp.frame_type)
               report_mismatch($sformatf("frame_type %02h, expected %02h",
                                         rsp_frame_type, head_rsp.frame_type));
            if (rsp_frame_cmd != head_rsp.frame_cmd)
               report_mismatch($sformatf("frame_cmd %02h, expected %02h",
                                         rsp_frame_cmd, head_rsp.frame_cmd));
            if (rsp_frame_ack != head_rsp.frame_ack)
               report_mismatch($sformatf("frame_ack %02h, expected %02h",
                                         rsp_frame_ack, head_rsp.frame_ack));
            if (rsp_payload_count != head_rsp.payload_count)
               report_mismatch($sformatf("payload_count %0d, expected %0d",
                                         rsp_payload_count, head_rsp.payload_count));
            if (rsp_frame_end != head_rsp.frame_end)
               report_mismatch($sformatf("frame_end %0d, expected %0d",
                                         rsp_frame_end, head_rsp.frame_end));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("crc32_frame_deframer_tb: errors");
         $finish;
      end
   end

   // Stimulus: reset, directed table, then random phases with new settings.
   initial begin : stimulus
      bit               got;
      cfd_pkg::rsp_type res;
      int unsigned      sent;
      sent = 0;
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_registers(32'hFFFF_FFFF, 16'hFFFF);

      // Directed bytes; the obvious responses are cross-checked here too.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         send_byte(PLAN[i].rx, got, res);
         if (got != PLAN[i].typed || (got && (res.kind != PLAN[i].kind ||
             res.data_byte != PLAN[i].data || res.payload_count != PLAN[i].count)))
            report_mismatch($sformatf("directed row %0d predicts kind %0d count %0d",
                                      i, res.kind, res.payload_count));
      end

      // Random stream; settings change between phases, often mid-frame.
      while (sent < RANDOM_ITEMS) begin
         if (sent % PHASE_ITEMS == 0) begin
            settle();
            case ((sent / PHASE_ITEMS) % 6)
               0: set_registers(32'h0000_0000, 16'd0);
               1: set_registers(32'hFFFF_FFFF, 16'd3);
               2: set_registers($urandom, 16'hFFFF);
               3: set_registers(cfd_pkg::SEED_RESET, cfd_pkg::MAX_PAYLOAD_RESET);
               4: set_registers($urandom, 16'($urandom_range(1, 15)));
               default: set_registers($urandom, 16'd1);
            endcase
         end
         if (sent >= QUIET_AFTER) quiet = 1'b1;
         if (rx_stream.size() == 0) queue_frame();
         send_byte(rx_stream.pop_front(), got, res);
         sent++;
      end

      settle();
      if (n_errors == 0) begin
         $display("crc32_frame_deframer_tb: clean");
      end else begin
         $display("crc32_frame_deframer_tb: errors");
      end
      $finish;
   end

endmodule
